/* hdl/linear_key_value_table_core_defines.svh */
// Assertion macros for the checker of the key/value table.
// No dependencies; include by bare file name.
`ifndef LINEAR_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// Checked only while out of reset.
`define LKV_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lkv assertion failed");

// Checked on every edge, reset included.
`define LKV_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lkv assertion failed");

`endif

/* hdl/lkv_pkg.sv */
// Shared types and constants for the linear key/value table.
// No dependencies; imported by every module of the block.
package lkv_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lkv_in_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic [IDX_W-1:0]      match_index;
    logic [CNT_W-1:0]      entry_count;
    logic                  is_empty;
    logic                  add_rejected;
  } lkv_out_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic                  active;
    logic [KEY_BITS-1:0]   key;
    logic                  found;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      index;
  } lkv_probe_t;

endpackage

/* hdl/lkv_cell.sv */
// One table entry plus one stage of the search chain.
// Depends on lkv_pkg.
module lkv_cell
  import lkv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  logic                  occupied_i,
  input  logic [IDX_W-1:0]      cell_idx_i,
  input  lkv_probe_t            probe_i,
  output lkv_probe_t            probe_o
);

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  lkv_probe_t            probe_d, probe_q;
  logic                  hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q   <= wr_key_i;
      value_q <= wr_value_i;
    end
  end

  // Earlier cells win: a probe already marked found passes through untouched.
  assign hit = probe_i.active && occupied_i && !probe_i.found && (key_q == probe_i.key);

  always_comb begin
    probe_d = probe_i;
    if (hit) begin
      probe_d.found = 1'b1;
      probe_d.value = value_q;
      probe_d.index = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

/* hdl/linear_key_value_table_core.sv */
// Channel | dir | handshake               | payload
// in      | in  | in_valid_i / in_ready_o  | lkv_in_t  in_data_i
// out     | out | out_valid_o / out_ready_i| lkv_out_t out_data_o
//
// Add: the entry is written into the cell at the fill position; a full table drops it.
// Lookup: the probe moves one cell per cycle down the chain.
// One item is in flight at a time; input is taken when idle and the output
//   register is empty or being drained in the same cycle.
// Reset clears the fill count and control; entry contents are left as they are.
// Depends on lkv_pkg and lkv_cell.
module linear_key_value_table_core
  import lkv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lkv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lkv_out_t out_data_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  lkv_out_t         out_data_q, out_data_d;
  logic             accept, add_xfer, table_full;
  lkv_probe_t       probe [TABLE_DEPTH+1];

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign add_xfer   = accept && (in_data_i.opcode == OP_ADD);
  assign table_full = (count_q == CNT_W'(TABLE_DEPTH));

  assign probe[0].active = accept && (in_data_i.opcode == OP_LOOKUP);
  assign probe[0].key    = in_data_i.key;
  assign probe[0].found  = 1'b0;
  assign probe[0].value  = '0;
  assign probe[0].index  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lkv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (add_xfer && !table_full && (count_q[IDX_W-1:0] == IDX_W'(i))),
      .wr_key_i   (in_data_i.key),
      .wr_value_i (in_data_i.value),
      .occupied_i (CNT_W'(i) < count_q),
      .cell_idx_i (IDX_W'(i)),
      .probe_i    (probe[i]),
      .probe_o    (probe[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (probe[0].active) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (probe[TABLE_DEPTH].active) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (add_xfer && !table_full) begin
      count_d = count_q + CNT_W'(1);
    end
    if (add_xfer) begin
      out_valid_d              = 1'b1;
      out_data_d.found         = 1'b0;
      out_data_d.value_out     = '0;
      out_data_d.match_index   = '0;
      out_data_d.entry_count   = count_d;
      out_data_d.is_empty      = (count_d == '0);
      out_data_d.add_rejected  = table_full;
    end else if (probe[TABLE_DEPTH].active) begin
      out_valid_d              = 1'b1;
      out_data_d.found         = probe[TABLE_DEPTH].found;
      out_data_d.value_out     = probe[TABLE_DEPTH].value;
      out_data_d.match_index   = probe[TABLE_DEPTH].index;
      out_data_d.entry_count   = count_q;
      out_data_d.is_empty      = (count_q == '0);
      out_data_d.add_rejected  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/lkv_checker.sv */
// Port-level checks for linear_key_value_table_core, attached by bind.
// Depends on lkv_pkg and linear_key_value_table_core_defines.svh.
`include "linear_key_value_table_core_defines.svh"

module lkv_checker
  import lkv_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input lkv_out_t out_data_o
);

  // A result that is not taken holds.
  `LKV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // Input transfer only when the output slot is free or draining.
  `LKV_ASSERT(a_in_slot, clk_i, rst_ni, in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)

  // A match lies among the held entries and never comes with a rejected add.
  `LKV_ASSERT(a_match_range, clk_i, rst_ni, out_valid_o && out_data_o.found |-> (CNT_W'(out_data_o.match_index) < out_data_o.entry_count) && !out_data_o.add_rejected && !out_data_o.is_empty)

  // A dropped add means the table was full.
  `LKV_ASSERT(a_reject_full, clk_i, rst_ni, out_valid_o && out_data_o.add_rejected |-> out_data_o.entry_count == CNT_W'(TABLE_DEPTH))

  `LKV_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind linear_key_value_table_core lkv_checker u_lkv_checker (.*);
